FILE: rtl/crc_chained_cursor_queue_core_assert.svh
// Assertion macros for the chained-CRC cursor queue.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef CRC_CHAINED_CURSOR_QUEUE_CORE_ASSERT_SVH
`define CRC_CHAINED_CURSOR_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CCQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CCQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/ccq_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the cursor queue.
// Used by the CRC cells, the CRC chain and the queue core; no dependencies.
package ccq_pkg;

   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 64;
   localparam int CRC_W = 32;
   localparam int SEQ_W = 32;
   localparam int KEY_BYTES = KEY_W / 8;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [KEY_W-1:0] KEY_NONE = '1;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

   typedef enum logic [3:0] {
      OP_PUSH          = 4'd0,
      OP_NEXT          = 4'd1,
      OP_FRONT         = 4'd2,
      OP_BACK          = 4'd3,
      OP_ERASE_THROUGH = 4'd4,
      OP_ERASE_BELOW   = 4'd5,
      OP_LOWER_BOUND   = 4'd6,
      OP_MARK_DEQUEUED = 4'd7,
      OP_COUNT_ABOVE   = 4'd8,
      OP_SIZE          = 4'd9,
      OP_CLEAR         = 4'd10,
      OP_CLEAR_DEQUEUE = 4'd11
   } op_type;

   // One stage of the CRC chain: the running register and the unconsumed key bytes.
   typedef struct packed {
      logic             vld;
      logic [CRC_W-1:0] crc;
      logic [KEY_W-1:0] key;
   } crc_stage_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SEQ_W-1:0] seq;
      logic [CRC_W-1:0] crc;
   } entry_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = c_in ^ {{(CRC_W-8){1'b0}}, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Physical slot of logical position pos; head + pos stays below twice the depth.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

FILE: rtl/ccq_crc_cell.sv
// One cell of the CRC chain: folds the low key byte into the running CRC.
// Depends on ccq_pkg.
module ccq_crc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ccq_pkg::crc_stage_type stage_i,
   output ccq_pkg::crc_stage_type stage_o
);

   ccq_pkg::crc_stage_type stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= stage_i.vld;
      end
      stage_ff.crc <= ccq_pkg::crc_byte(stage_i.crc, stage_i.key[7:0]);
      stage_ff.key <= stage_i.key >> 8;
   end

   assign stage_o = stage_ff;

endmodule

FILE: rtl/ccq_crc_chain.sv
// Row of CRC cells, one per key byte, giving the chained CRC-32 of a key.
// Depends on ccq_pkg and ccq_crc_cell.
module ccq_crc_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ccq_pkg::CRC_W-1:0]   seed,
   input  logic [ccq_pkg::KEY_W-1:0]   key,
   output logic                        done,
   output logic [ccq_pkg::CRC_W-1:0]   crc
);

   ccq_pkg::crc_stage_type stage [0:ccq_pkg::KEY_BYTES];

   assign stage[0].vld = start;
   assign stage[0].crc = ~seed;
   assign stage[0].key = key;

   for (genvar i = 0; i < ccq_pkg::KEY_BYTES; i++) begin : g_cell
      ccq_crc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .stage_i (stage[i]),
         .stage_o (stage[i+1])
      );
   end

   assign done = stage[ccq_pkg::KEY_BYTES].vld;
   assign crc  = ~stage[ccq_pkg::KEY_BYTES].crc;

endmodule

FILE: rtl/crc_chained_cursor_queue_core.sv
// Chained-CRC cursor queue: a circular record memory of strictly rising keys, a
// binary-search sequencer and a row of eight CRC cells, one per key byte. One
// word is handled at a time. Size, clear, back and the dequeue reset answer
// from registers; front and a next without a key read one record; searches
// probe the memory (up to 9 probes at 256 entries) and then read the found
// record; push and a checked next also pass through the CRC row.
// Depends on ccq_pkg, ccq_crc_chain and crc_chained_cursor_queue_core_assert.svh.
`include "crc_chained_cursor_queue_core_assert.svh"
module crc_chained_cursor_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_type,
   input  logic [ccq_pkg::KEY_W-1:0]   req_cursor_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [ccq_pkg::KEY_W-1:0]   rsp_key_out,
   output logic [ccq_pkg::SEQ_W-1:0]   rsp_seq_out,
   output logic [ccq_pkg::CRC_W-1:0]   rsp_crc_out,
   output logic                        rsp_crc_pass,
   output logic [31:0]                 rsp_count_out
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_PROBE, S_PROBE_EVAL, S_FOUND, S_FETCH, S_FETCH_EVAL,
      S_CRC, S_DONE
   } state_type;

   state_type                     st_ff;
   ccq_pkg::op_type               op_ff;
   logic [ccq_pkg::KEY_W-1:0]     key_ff;
   logic [ccq_pkg::CNT_W-1:0]     lo_ff, hi_ff, fill_ff;
   logic [ccq_pkg::PTR_W-1:0]     head_ff;
   logic [ccq_pkg::KEY_W-1:0]     back_key_ff, last_key_ff;
   logic [ccq_pkg::SEQ_W-1:0]     back_seq_ff, last_seq_ff;
   logic [ccq_pkg::CRC_W-1:0]     back_crc_ff, last_crc_ff;
   logic                          ok_ff, pass_ff;
   logic [ccq_pkg::KEY_W-1:0]     key_out_ff;
   logic [ccq_pkg::SEQ_W-1:0]     seq_out_ff;
   logic [ccq_pkg::CRC_W-1:0]     crc_out_ff;
   logic [31:0]                   count_ff;
   logic                          crc_go_ff;
   logic [ccq_pkg::CRC_W-1:0]     crc_seed_ff;
   logic [ccq_pkg::KEY_W-1:0]     crc_key_ff;

   ccq_pkg::entry_type            mem [0:ccq_pkg::DEPTH-1];
   ccq_pkg::entry_type            rd_data_ff;
   ccq_pkg::entry_type            wr_rec_in;
   logic [ccq_pkg::PTR_W-1:0]     rd_addr_in, wr_addr_in;
   logic                          mem_we_in;

   logic [ccq_pkg::CNT_W:0]       mid_sum;
   logic [ccq_pkg::CNT_W-1:0]     mid;
   logic                          strict, pred, chk, take_deq, found;
   logic                          crc_done;
   logic [ccq_pkg::CRC_W-1:0]     crc_val;

   ccq_crc_chain u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_go_ff),
      .seed  (crc_seed_ff),
      .key   (crc_key_ff),
      .done  (crc_done),
      .crc   (crc_val)
   );

   always_comb begin
      mid_sum    = (ccq_pkg::CNT_W+1)'(lo_ff) + (ccq_pkg::CNT_W+1)'(hi_ff);
      mid        = mid_sum[ccq_pkg::CNT_W:1];
      rd_addr_in = (st_ff == S_PROBE) ? ccq_pkg::slot_of(head_ff, mid)
                                      : ccq_pkg::slot_of(head_ff, lo_ff);
      strict     = (op_ff == ccq_pkg::OP_NEXT) || (op_ff == ccq_pkg::OP_ERASE_THROUGH) ||
                   (op_ff == ccq_pkg::OP_COUNT_ABOVE);
      pred       = strict ? (rd_data_ff.key > key_ff) : (rd_data_ff.key >= key_ff);
      chk        = (last_key_ff != ccq_pkg::KEY_NONE) && (last_key_ff < rd_data_ff.key);
      take_deq   = (last_key_ff == ccq_pkg::KEY_NONE) || (last_key_ff < rd_data_ff.key);
      found      = lo_ff < fill_ff;
      mem_we_in  = (st_ff == S_CRC) && crc_done && (op_ff == ccq_pkg::OP_PUSH);
      wr_addr_in = ccq_pkg::slot_of(head_ff, fill_ff);
      wr_rec_in  = '{key: key_ff, seq: seq_out_ff, crc: crc_val};
   end

   always_ff @(posedge clock) begin
      if (mem_we_in) begin
         mem[wr_addr_in] <= wr_rec_in;
      end
      rd_data_ff <= mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         last_key_ff <= ccq_pkg::KEY_NONE;
         last_seq_ff <= '0;
         last_crc_ff <= '0;
         crc_go_ff   <= 1'b0;
      end else begin
         crc_go_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff      <= ccq_pkg::op_type'(req_type);
                  key_ff     <= req_cursor_key;
                  ok_ff      <= 1'b0;
                  pass_ff    <= 1'b1;
                  key_out_ff <= '0;
                  seq_out_ff <= '0;
                  crc_out_ff <= '0;
                  count_ff   <= '0;
                  st_ff      <= S_START;
               end
            end
            S_START: begin
               case (op_ff)
                  ccq_pkg::OP_PUSH: begin
                     if (key_ff == ccq_pkg::KEY_NONE || fill_ff >= ccq_pkg::DEPTH_CNT ||
                         (fill_ff != '0 && !(back_key_ff < key_ff))) begin
                        st_ff <= S_DONE;
                     end else begin
                        crc_go_ff   <= 1'b1;
                        crc_seed_ff <= (fill_ff != '0) ? back_crc_ff : last_crc_ff;
                        crc_key_ff  <= key_ff;
                        seq_out_ff  <= (fill_ff != '0) ? back_seq_ff + 1'b1 : '0;
                        st_ff       <= S_CRC;
                     end
                  end
                  ccq_pkg::OP_NEXT: begin
                     lo_ff <= '0;
                     hi_ff <= fill_ff;
                     if (fill_ff == '0) begin
                        st_ff <= S_DONE;
                     end else if (key_ff == ccq_pkg::KEY_NONE) begin
                        st_ff <= S_FETCH;
                     end else begin
                        st_ff <= S_PROBE;
                     end
                  end
                  ccq_pkg::OP_FRONT: begin
                     lo_ff <= '0;
                     st_ff <= (fill_ff == '0) ? S_DONE : S_FETCH;
                  end
                  ccq_pkg::OP_BACK: begin
                     if (fill_ff != '0) begin
                        ok_ff      <= 1'b1;
                        key_out_ff <= back_key_ff;
                        seq_out_ff <= back_seq_ff;
                        crc_out_ff <= back_crc_ff;
                     end
                     st_ff <= S_DONE;
                  end
                  ccq_pkg::OP_ERASE_THROUGH, ccq_pkg::OP_ERASE_BELOW,
                  ccq_pkg::OP_LOWER_BOUND, ccq_pkg::OP_MARK_DEQUEUED: begin
                     lo_ff <= '0;
                     hi_ff <= fill_ff;
                     st_ff <= (key_ff == ccq_pkg::KEY_NONE) ? S_DONE : S_PROBE;
                  end
                  ccq_pkg::OP_COUNT_ABOVE: begin
                     lo_ff <= '0;
                     hi_ff <= fill_ff;
                     st_ff <= S_PROBE;
                  end
                  ccq_pkg::OP_SIZE: begin
                     ok_ff    <= 1'b1;
                     count_ff <= 32'(fill_ff);
                     st_ff    <= S_DONE;
                  end
                  ccq_pkg::OP_CLEAR: begin
                     ok_ff   <= 1'b1;
                     fill_ff <= '0;
                     head_ff <= '0;
                     st_ff   <= S_DONE;
                  end
                  ccq_pkg::OP_CLEAR_DEQUEUE: begin
                     ok_ff       <= 1'b1;
                     last_key_ff <= ccq_pkg::KEY_NONE;
                     last_seq_ff <= '0;
                     last_crc_ff <= '0;
                     st_ff       <= S_DONE;
                  end
                  default: begin
                     st_ff <= S_DONE;
                  end
               endcase
            end
            S_PROBE: begin
               st_ff <= (lo_ff == hi_ff) ? S_FOUND : S_PROBE_EVAL;
            end
            S_PROBE_EVAL: begin
               if (pred) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid + 1'b1;
               end
               st_ff <= S_PROBE;
            end
            S_FOUND: begin
               if (op_ff == ccq_pkg::OP_ERASE_THROUGH || op_ff == ccq_pkg::OP_ERASE_BELOW) begin
                  ok_ff <= 1'b1;
                  if (!found) begin
                     fill_ff <= '0;
                  end else begin
                     head_ff <= ccq_pkg::slot_of(head_ff, lo_ff);
                     fill_ff <= fill_ff - lo_ff;
                  end
                  st_ff <= S_DONE;
               end else begin
                  st_ff <= found ? S_FETCH : S_DONE;
               end
            end
            S_FETCH: begin
               st_ff <= S_FETCH_EVAL;
            end
            S_FETCH_EVAL: begin
               ok_ff <= 1'b1;
               if (op_ff == ccq_pkg::OP_COUNT_ABOVE) begin
                  count_ff <= back_seq_ff - rd_data_ff.seq + 1'b1;
                  st_ff    <= S_DONE;
               end else begin
                  key_out_ff <= rd_data_ff.key;
                  seq_out_ff <= rd_data_ff.seq;
                  crc_out_ff <= rd_data_ff.crc;
                  if (op_ff == ccq_pkg::OP_NEXT && chk) begin
                     // The chain check runs before the dequeue record moves on.
                     crc_go_ff   <= 1'b1;
                     crc_seed_ff <= last_crc_ff;
                     crc_key_ff  <= rd_data_ff.key;
                     st_ff       <= S_CRC;
                  end else begin
                     if ((op_ff == ccq_pkg::OP_NEXT || op_ff == ccq_pkg::OP_MARK_DEQUEUED) &&
                         take_deq) begin
                        last_key_ff <= rd_data_ff.key;
                        last_seq_ff <= rd_data_ff.seq;
                        last_crc_ff <= rd_data_ff.crc;
                     end
                     st_ff <= S_DONE;
                  end
               end
            end
            S_CRC: begin
               if (crc_done) begin
                  if (op_ff == ccq_pkg::OP_PUSH) begin
                     ok_ff       <= 1'b1;
                     key_out_ff  <= key_ff;
                     crc_out_ff  <= crc_val;
                     back_key_ff <= key_ff;
                     back_seq_ff <= seq_out_ff;
                     back_crc_ff <= crc_val;
                     fill_ff     <= fill_ff + 1'b1;
                  end else begin
                     pass_ff     <= (crc_out_ff == crc_val);
                     last_key_ff <= key_out_ff;
                     last_seq_ff <= seq_out_ff;
                     last_crc_ff <= crc_out_ff;
                  end
                  st_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_stall) begin
                  st_ff <= S_IDLE;
               end
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (st_ff != S_IDLE);
   assign rsp_valid     = (st_ff == S_DONE);
   assign rsp_ok        = ok_ff;
   assign rsp_key_out   = key_out_ff;
   assign rsp_seq_out   = seq_out_ff;
   assign rsp_crc_out   = crc_out_ff;
   assign rsp_crc_pass  = pass_ff;
   assign rsp_count_out = count_ff;

   `CCQ_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= ccq_pkg::DEPTH_CNT, "fill")
   `CCQ_ASSERT_NOW(a_push_room, clock, reset, mem_we_in, fill_ff < ccq_pkg::DEPTH_CNT, "full")
   `CCQ_ASSERT_NOW(a_crc_in_state, clock, reset, crc_done, st_ff == S_CRC, "CRC outside wait")
   `CCQ_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid, "early")

endmodule
